/* hw/rtl/bilateral_filter_3x3_core_defines.svh */
// ---------------------------------------------------------------------------
// bilateral_filter_3x3_core_defines
// assertion macros shared by the filter core
// ---------------------------------------------------------------------------
`ifndef BILATERAL_FILTER_3X3_CORE_DEFINES_SVH
`define BILATERAL_FILTER_3X3_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bf3_pkg.sv */
// ---------------------------------------------------------------------------
// bf3_pkg
// types, register codes and range weight table of the 3x3 bilateral filter
// ---------------------------------------------------------------------------
package bf3_pkg;

  localparam int unsigned MaxWidthDefault = 4096;
  localparam int unsigned RangeSigma      = 25;
  localparam longint unsigned RomM        = 2 * RangeSigma * RangeSigma;
  localparam longint unsigned OneQ32      = 64'h1_0000_0000;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBorderWeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCornerWeight = 2'd2;

  localparam logic [12:0] WidthReset  = 13'd4096;
  localparam logic [15:0] BorderReset = 16'd39750;
  localparam logic [15:0] CornerReset = 16'd24109;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  smooth_value;
    logic [11:0] center_row;
    logic [11:0] center_col;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } bf3_state_e;

  // shift-subtract quotient, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-r/RomM) in q32 by a series up to the 24th power
  function automatic logic [63:0] exp_part(input logic [63:0] r);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = OneQ32;
    neg  = '0;
    term = OneQ32;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(term * r, RomM * 64'(k));
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic logic [256*17-1:0] build_rom();
    logic [256*17-1:0] rom;
    logic [63:0]       e1;
    logic [63:0]       n;
    logic [63:0]       q;
    logic [63:0]       v;
    rom = '0;
    e1  = exp_part(RomM);
    for (int d = 0; d < 256; d++) begin
      n = 64'(d) * 64'(d);
      q = udiv64(n, RomM);
      v = exp_part(n - q * RomM);
      while (q > 0 && v != 0) begin
        v = (v * e1) >> 32;
        q = q - 1;
      end
      v = (v + 64'd32768) >> 16;
      rom[d*17 +: 17] = v[16:0];
    end
    return rom;
  endfunction

  localparam logic [256*17-1:0] RangeRom = build_rom();

  function automatic logic [16:0] range_weight(input logic [7:0] d);
    return RangeRom[d*17 +: 17];
  endfunction

endpackage

/* hw/rtl/bilateral_filter_3x3_core.sv */
// ---------------------------------------------------------------------------
// bilateral_filter_3x3_core
// streaming 3x3 bilateral filter on one 8-bit plane
// ---------------------------------------------------------------------------
// usage:
//   input beats carry one sample in raster order; frame_start marks the
//   first pixel of a frame and zeroes the row and column counters.
//   an output beat is given only for interior centers, with the center's
//   row and column; edge pixels produce no beat.
//   configuration (width, border and corner weights) is written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while the core is idle.
// timing:
//   one item at a time. an item with no result passes only through the
//   line store read and write; an item with a result goes on through the
//   eight neighbour weights on one shared multiplier pair, the divider
//   start, the bit-serial divider (no serial steps when the quotient
//   saturates at 255) and the output load, where its beat is registered.
//   the output register holds a finished beat while the receiver stalls;
//   new samples are still taken, and a later result waits with in_stall_o
//   high until the register drains.
// reset:
//   counters, window, state, valid flags and configuration reset at once;
//   data registers and line stores are not cleared; the stores are filled by the first two rows of a frame.
// ---------------------------------------------------------------------------
`include "bilateral_filter_3x3_core_defines.svh"

module bilateral_filter_3x3_core #(
  parameter int unsigned MAX_WIDTH = bf3_pkg::MaxWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bf3_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bf3_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bf3_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bf3_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import bf3_pkg::*;

  localparam int unsigned AW       = $clog2(MAX_WIDTH);
  localparam int unsigned WidthCap = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

  // configuration registers
  logic [12:0] width_q;
  logic [15:0] border_q;
  logic [15:0] corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      border_q <= BorderReset;
      corner_q <= CornerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:   width_q  <= cfg_wdata_i[12:0];
        CfgBorderWeight: border_q <= cfg_wdata_i;
        CfgCornerWeight: corner_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // state
  bf3_state_e  state_q, state_d;
  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [7:0]  win_q [9];
  logic [7:0]  win_d [9];
  logic [7:0]  sample_q, sample_d;
  logic [AW-1:0] addr_q, addr_d;
  logic        emit_q, emit_d;
  logic [11:0] crow_q, crow_d;
  logic [11:0] ccol_q, ccol_d;
  logic [3:0]  k_q, k_d;
  logic [15:0] w_q, w_d;
  logic [7:0]  v_q, v_d;
  logic [27:0] num_q, num_d;
  logic [19:0] den_q, den_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;

  // accept side
  logic        in_acc;
  logic [11:0] cur_c;
  logic [11:0] cur_r;
  logic [12:0] weff;
  logic [AW-1:0] rd_addr;
  logic [7:0]  rd_above;
  logic [7:0]  rd_two;

  // weight path
  logic [3:0]  nb_idx;
  logic [7:0]  nb_val;
  logic [7:0]  nb_diff;
  logic [15:0] nb_sp;
  logic [32:0] nb_prod;
  logic [23:0] acc_prod;

  // divider
  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [7:0]  div_quo;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cur_c      = in_data_i.frame_start ? 12'd0 : col_q;
  assign cur_r      = in_data_i.frame_start ? 12'd0 : row_q;

  // width clamped to 3..min(MAX_WIDTH, 4096)
  always_comb begin
    if (width_q < 13'd3) weff = 13'd3;
    else if (32'(width_q) > WidthCap) weff = 13'(WidthCap);
    else weff = width_q;
  end

  always_comb begin
    if (32'(cur_c) < MAX_WIDTH) rd_addr = AW'(cur_c);
    else rd_addr = AW'(MAX_WIDTH - 1);
  end

  bf3_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_lines (
    .clk_i      (clk_i),
    .rd_en_i    (in_acc),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (state_q == ST_LOAD),
    .wr_addr_i  (addr_q),
    .wr_above_i (sample_q),
    .wr_two_i   (rd_above),
    .rd_above_o (rd_above),
    .rd_two_o   (rd_two)
  );

  // neighbour k maps to window slot k, skipping the center
  assign nb_idx  = (k_q < 4'd4) ? k_q : k_q + 4'd1;
  assign nb_val  = win_q[nb_idx];
  assign nb_diff = (nb_val > win_q[4]) ? nb_val - win_q[4] : win_q[4] - nb_val;
  assign nb_sp   = nb_idx[0] ? border_q : corner_q;   // odd slots are edge neighbours
  assign nb_prod = 33'(nb_sp) * 33'(range_weight(nb_diff));
  assign acc_prod = 24'(w_q) * 24'(v_q);

  assign div_start = (state_q == ST_DSTART);

  bf3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    win_d       = win_q;
    sample_d    = sample_q;
    addr_d      = addr_q;
    emit_d      = emit_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    k_d         = k_q;
    w_d         = w_q;
    v_d         = v_q;
    num_d       = num_q;
    den_d       = den_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sample_d = in_data_i.sample_value;
          addr_d   = rd_addr;
          emit_d   = (cur_r >= 12'd2) && (cur_c >= 12'd2);
          crow_d   = cur_r - 12'd1;
          ccol_d   = cur_c - 12'd1;
          if ({1'b0, cur_c} + 13'd1 >= weff) begin
            col_d = '0;
            if (cur_r != 12'hfff) row_d = cur_r + 12'd1;
            else row_d = cur_r;
          end else begin
            col_d = cur_c + 12'd1;
            row_d = cur_r;
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // line store data is here: shift the window in
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = rd_two;
        win_d[3] = win_q[4];
        win_d[4] = win_q[5];
        win_d[5] = rd_above;
        win_d[6] = win_q[7];
        win_d[7] = win_q[8];
        win_d[8] = sample_q;
        num_d    = {4'd0, win_q[5], 16'd0};
        den_d    = 20'h10000;
        k_d      = '0;
        state_d  = emit_q ? ST_ACC : ST_IDLE;
      end
      ST_ACC: begin
        // weight of neighbour k, accumulate neighbour k-1
        if (k_q != 4'd8) begin
          w_d = nb_prod[31:16];
          v_d = nb_val;
        end
        if (k_q != 4'd0) begin
          num_d = num_q + 28'(acc_prod);
          den_d = den_q + 20'(w_q);
        end
        k_d = k_q + 4'd1;
        if (k_q == 4'd8) state_d = ST_DSTART;
      end
      ST_DSTART: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d        = 1'b1;
          out_d.smooth_value = div_quo;
          out_d.center_row   = crow_q;
          out_d.center_col   = ccol_q;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '{default: '0};
      emit_q      <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      win_q       <= win_d;
      emit_q      <= emit_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    addr_q   <= addr_d;
    crow_q   <= crow_d;
    ccol_q   <= ccol_d;
    w_q      <= w_d;
    v_q      <= v_d;
    num_q    <= num_d;
    den_q    <= den_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // accepted beat goes to the line store write cycle next
  `BF3_ASSERT_NEXT(a_accept_load, in_acc, state_q == ST_LOAD, "accept did not start load")
  // divider is only started when free
  `BF3_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
  // center weight keeps the denominator at or above one
  `BF3_ASSERT_NOW(a_den_min, state_q == ST_DSTART, den_q[19:16] != 4'd0, "denominator below one")
endmodule

/* hw/rtl/bf3_line_store.sv */
// ---------------------------------------------------------------------------
// bf3_line_store
// the two previous rows, one synchronous memory each
// ---------------------------------------------------------------------------
module bf3_line_store #(
  parameter int unsigned MAX_WIDTH = bf3_pkg::MaxWidthDefault,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_above_i,
  input  logic [7:0]    wr_two_i,
  output logic [7:0]    rd_above_o,
  output logic [7:0]    rd_two_o
);
  import bf3_pkg::*;

  logic [7:0] above_mem [MAX_WIDTH];
  logic [7:0] two_mem   [MAX_WIDTH];
  logic [7:0] above_q;
  logic [7:0] two_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      above_mem[wr_addr_i] <= wr_above_i;
      two_mem[wr_addr_i]   <= wr_two_i;
    end
    if (rd_en_i) begin
      above_q <= above_mem[rd_addr_i];
      two_q   <= two_mem[rd_addr_i];
    end
  end

  assign rd_above_o = above_q;
  assign rd_two_o   = two_q;
endmodule

/* hw/rtl/bf3_divider.sv */
// ---------------------------------------------------------------------------
// bf3_divider
// restoring divider, one quotient bit a cycle, saturating at 255
// ---------------------------------------------------------------------------
module bf3_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] num_i,
  input  logic [19:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [7:0]  quo_o
);
  import bf3_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [27:0] rem_q, rem_d;
  logic [27:0] dsh_q, dsh_d;
  logic [7:0]  quo_q, quo_d;
  logic        ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      if (num_i >= {den_i, 8'd0}) begin
        quo_d  = 8'hff;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = 4'd8;
        rem_d  = num_i;
        dsh_d  = {1'b0, den_i, 7'd0};
        quo_d  = '0;
      end
    end else if (busy_q) begin
      if (ge) rem_d = rem_q - dsh_q;
      quo_d = {quo_q[6:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

/* sim/tb_bilateral_filter_3x3_core.sv */
// ---------------------------------------------------------------------------
// tb_bilateral_filter_3x3_core
// self-checking bench for the streaming 3x3 bilateral filter core
// ---------------------------------------------------------------------------
// samples are streamed in raster order, in frames whose sizes vary by phase.
// a scoreboard holds its own line buffers, window and range weight table,
// predicts each interior center, and compares every output beat field by field.
// the phases cover the reset settings, extreme weights, clamped widths, and a
// narrowing of the width in the middle of a row. they also run random phases
// under several sender and receiver idle mixes, and an oversized width that clamps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bilateral_filter_3x3_core;
  import bf3_pkg::*;

  localparam int unsigned IdleLimit  = 4000;  // cycles with no beat accepted
  localparam int unsigned DrainCycles = 40;   // above the time of one item with a result

  // scoreboard: shadow filter state and queue of predicted centers
  class bf3_scoreboard;
    logic [16:0] range_lut[256];
    logic [7:0]  row_prev[4096];
    logic [7:0]  row_prev2[4096];
    logic [7:0]  win[9];
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic [12:0] width_reg;
    logic [15:0] border_w;
    logic [15:0] corner_w;
    out_beat_t   pending[$];
    int unsigned mismatches;

    function new();
      longint unsigned m, e1, n, q, v;
      m  = 2 * RangeSigma * RangeSigma;
      e1 = exp_q32(m, m);
      for (int d = 0; d < 256; d++) begin
        n = longint'(d) * longint'(d);
        q = n / m;
        v = exp_q32(n % m, m);
        while (q > 0 && v != 0) begin
          v = (v * e1) >> 32;
          q--;
        end
        range_lut[d] = 17'((v + 32768) >> 16);
      end
      foreach (win[i]) win[i] = '0;
      col_pos = '0;
      row_pos = '0;
      width_reg = WidthReset;
      border_w = BorderReset;
      corner_w = CornerReset;
      mismatches = 0;
    endfunction

    // exp(-r/m) in q32, alternating series
    function longint unsigned exp_q32(longint unsigned r, longint unsigned m);
      longint unsigned plus, minus, term;
      plus = 64'h1_0000_0000;
      minus = 0;
      term = 64'h1_0000_0000;
      for (int k = 1; k <= 24; k++) begin
        term = (term * r) / (m * k);
        if (k % 2) minus += term;
        else plus += term;
      end
      return (plus > minus) ? plus - minus : 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgImageWidth:   width_reg = val[12:0];
        CfgBorderWeight: border_w = val;
        CfgCornerWeight: corner_w = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] filter_center();
      longint unsigned num, den, wt;
      logic [7:0] ctr, nb, diff;
      ctr = win[4];
      num = 65536 * ctr;
      den = 65536;
      for (int i = 0; i < 9; i++) begin
        if (i == 4) continue;
        nb = win[i];
        diff = (nb > ctr) ? nb - ctr : ctr - nb;
        wt = (((i % 2) ? border_w : corner_w) * longint'(range_lut[diff])) >> 16;
        num += wt * nb;
        den += wt;
      end
      num = num / den;
      return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    function void note_sample(in_beat_t beat);
      int unsigned w;
      logic [11:0] c, r;
      out_beat_t exp_beat;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > 4096) w = 4096;
      if (beat.frame_start) begin
        col_pos = '0;
        row_pos = '0;
      end
      c = col_pos;
      r = row_pos;
      win[0] = win[1]; win[1] = win[2]; win[2] = row_prev2[c];
      win[3] = win[4]; win[4] = win[5]; win[5] = row_prev[c];
      win[6] = win[7]; win[7] = win[8]; win[8] = beat.sample_value;
      row_prev2[c] = row_prev[c];
      row_prev[c] = beat.sample_value;
      if (r >= 2 && c >= 2) begin
        exp_beat.smooth_value = filter_center();
        exp_beat.center_row = r - 1;
        exp_beat.center_col = c - 1;
        pending.push_back(exp_beat);
      end
      if (c + 1 >= w) begin
        col_pos = '0;
        if (row_pos != 12'hfff) row_pos++;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: value %0d row %0d col %0d",
                   got.smooth_value, got.center_row, got.center_col);
        return;
      end
      want = pending.pop_front();
      if (got.smooth_value !== want.smooth_value || got.center_row !== want.center_row
          || got.center_col !== want.center_col) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d row %0d col %0d, got %0d row %0d col %0d",
                   want.smooth_value, want.center_row, want.center_col,
                   got.smooth_value, got.center_row, got.center_col);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_beat_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgImageWidth;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;   // chance the sender idles on a cycle
  int unsigned stall_pct = 0;       // chance the receiver stalls on a cycle
  int unsigned quiet_cycles = 0;
  bf3_scoreboard filt_sb = new();

  bilateral_filter_3x3_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // monitor: note accepted samples, check accepted results, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) filt_sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) filt_sb.check_beat(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one sample beat; valid stays high into the next beat when no idle falls
  task automatic send_sample(logic [7:0] value, logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.sample_value = value;
    in_data_i.frame_start = fs;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    filt_sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // wait for every predicted center, then let the last item finish
  task automatic drain();
    while (filt_sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128 + 8'($urandom_range(20));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one frame of random content, with an occasional stray frame start
  task automatic send_frame(int unsigned width, int unsigned rows);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < width; c++)
        send_sample(rand_sample(), (r == 0 && c == 0) || ($urandom_range(199) == 0));
  endtask

  initial begin
    int unsigned width;
    logic [15:0] bw, cw;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset settings, no frame start, full-scale extremes
    for (int i = 0; i < 8; i++) send_sample((i % 3 == 0) ? 8'd255 : 8'd0, 1'b0);
    drain();
    write_reg(CfgImageWidth, 16'd3);
    write_reg(CfgBorderWeight, 16'd0);
    write_reg(CfgCornerWeight, 16'hffff);
    for (int i = 0; i < 9; i++) send_sample((i == 4) ? 8'd0 : 8'd255, i == 0);
    send_sample(8'd255, 1'b0);
    drain();
    write_reg(CfgBorderWeight, 16'hffff);
    write_reg(CfgCornerWeight, 16'd0);
    for (int i = 0; i < 9; i++) send_sample((i == 4) ? 8'd255 : 8'd0, i == 0);
    drain();

    // width narrowed in the middle of a row
    write_reg(CfgImageWidth, 16'd6);
    for (int i = 0; i < 16; i++) send_sample(8'($urandom_range(255)), i == 0);
    drain();
    write_reg(CfgImageWidth, 16'd3);
    for (int i = 0; i < 12; i++) send_sample(8'($urandom_range(255)), 1'b0);
    drain();

    // random phases with the idle mixes in turn
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      width = (ph == 5) ? $urandom_range(2) : $urandom_range(3, 8);
      bw = (ph % 5 == 0) ? 16'hffff : 16'($urandom_range(65535));
      cw = (ph % 7 == 0) ? 16'd0 : 16'($urandom_range(65535));
      write_reg(CfgImageWidth, 16'(width));
      write_reg(CfgBorderWeight, bw);
      write_reg(CfgCornerWeight, cw);
      if (width < 3) width = 3;
      send_frame(width, $urandom_range(3, 5));
      if (ph % 4 == 1) drain();  // sender pauses until all results are back
      send_frame(width, 3);
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;

    // oversized width clamps to full rows: no wrap within the first row
    write_reg(CfgImageWidth, 16'd8191);
    write_reg(CfgBorderWeight, BorderReset);
    write_reg(CfgCornerWeight, CornerReset);
    for (int i = 0; i < 20; i++) send_sample(8'($urandom_range(255)), i == 0);
    drain();

    if (filt_sb.pending.size() != 0) filt_sb.mismatches++;
    if (filt_sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
